// ----- rtl/core/rau_pkg.sv -----
// rau_pkg: shared types and constants for the rational arithmetic unit
// no dependencies
`default_nettype none
package rau_pkg;
    localparam int RES_W = 64;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4,
        OP_RED = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_COMB,
        ST_SIGN,
        ST_GCD_INIT,
        ST_GCD_DIV,
        ST_GCD_STEP,
        ST_QN,
        ST_QD,
        ST_FIN,
        ST_OUT
    } t_state;

    // datapath commands from the controller
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic comb;
        logic sign;
        logic gcd_init;
        logic div_start;
        logic div_sel_qn;
        logic div_sel_qd;
        logic gcd_step;
        logic store_qn;
        logic store_qd;
        logic fin;
    } t_cmd;

    // datapath status to the controller
    typedef struct packed {
        logic is_neg_op;
        logic need_reduce;
        logic y_zero;
        logic div_done;
    } t_sts;
endpackage
`default_nettype wire

// ----- rtl/core/rau_div.sv -----
// rau_div: 64-bit unsigned restoring divider, one quotient bit per cycle
// depends on rau_pkg
`default_nettype none
module rau_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [rau_pkg::RES_W-1:0] i_dividend,
    input  wire logic [rau_pkg::RES_W-1:0] i_divisor,
    output logic                          o_done,
    output logic [rau_pkg::RES_W-1:0]     o_quot,
    output logic [rau_pkg::RES_W-1:0]     o_rem
);
    import rau_pkg::*;

    logic [RES_W-1:0] r_q, n_q, r_r, n_r, r_d;
    logic [6:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic [RES_W:0]   w_trial;
    logic [RES_W:0]   w_sh;

    always_comb begin
        w_sh    = {r_r, r_q[RES_W-1]};
        w_trial = w_sh - {1'b0, r_d};
        n_q     = r_q;
        n_r     = r_r;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        if (i_start) begin
            n_q    = i_dividend;
            n_r    = '0;
            n_cnt  = 7'(RES_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[RES_W]) begin
                n_r = w_trial[RES_W-1:0];
                n_q = {r_q[RES_W-2:0], 1'b1};
            end else begin
                n_r = w_sh[RES_W-1:0];
                n_q = {r_q[RES_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        if (i_start) begin
            r_d <= i_divisor;
        end
    end

    assign o_done = !r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule
`default_nettype wire

// ----- rtl/core/rau_dp.sv -----
// rau_dp: operand registers, multipliers, sign normalization and gcd datapath
// depends on rau_pkg, rau_div
`default_nettype none
module rau_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire rau_pkg::t_cmd            i_cmd,
    input  wire logic [2:0]               i_op,
    input  wire logic [31:0]              i_a_num,
    input  wire logic [31:0]              i_a_den,
    input  wire logic [31:0]              i_b_num,
    input  wire logic [31:0]              i_b_den,
    output rau_pkg::t_sts                 o_sts,
    output logic [rau_pkg::RES_W-1:0]     o_res_num,
    output logic [rau_pkg::RES_W-1:0]     o_res_den
);
    import rau_pkg::*;

    logic [2:0]       r_op;
    logic [RES_W-1:0] r_an, r_ad, r_bn, r_bd;
    logic [RES_W-1:0] r_p1, r_p2, r_p3;
    logic [RES_W-1:0] r_n, r_d, r_x, r_y, r_g, r_qn;
    logic [RES_W-1:0] w_m1a, w_m1b, w_m2a, w_m2b, w_div_a, w_div_b;
    logic [RES_W-1:0] w_mag_n, w_quot, w_rem;
    logic             w_div_done;

    function automatic logic [RES_W-1:0] sext(input logic [31:0] v);
        return {{(RES_W-DATA_WIDTH){v[DATA_WIDTH-1]}}, v[DATA_WIDTH-1:0]};
    endfunction

    assign w_mag_n = r_n[RES_W-1] ? (RES_W'(0) - r_n) : r_n;

    // multiplier operand selection
    always_comb begin
        w_m1a = r_an;
        w_m1b = r_bd;
        w_m2a = r_ad;
        w_m2b = r_bd;
        case (r_op)
            OP_ADD, OP_SUB: begin
                // the mul2 step reuses the first multiplier for the denominator
                if (i_cmd.mul2) begin
                    w_m1a = r_ad; w_m1b = r_bd;
                end else begin
                    w_m1a = r_an; w_m1b = r_bd;
                end
                w_m2a = r_bn; w_m2b = r_ad;
            end
            OP_MUL: begin
                w_m1a = r_an; w_m1b = r_bn; w_m2a = r_ad; w_m2b = r_bd;
            end
            OP_DIV: begin
                w_m1a = r_an; w_m1b = r_bd; w_m2a = r_ad; w_m2b = r_bn;
            end
            default: begin
                w_m1a = r_an; w_m1b = r_bd; w_m2a = r_ad; w_m2b = r_bd;
            end
        endcase
    end

    always_comb begin
        w_div_a = r_x;
        w_div_b = r_y;
        if (i_cmd.div_sel_qn) begin
            w_div_a = w_mag_n;
            w_div_b = r_g;
        end else if (i_cmd.div_sel_qd) begin
            w_div_a = r_d;
            w_div_b = r_g;
        end
    end

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_an <= sext(i_a_num);
            r_ad <= sext(i_a_den);
            r_bn <= sext(i_b_num);
            r_bd <= sext(i_b_den);
        end
        // 32x32 signed products, low 64 bits
        if (i_cmd.mul1 || i_cmd.mul2) begin
            r_p1 <= w_m1a[31:0] * w_m1b[31:0] +
                    ({{32{1'b0}}, (w_m1a[63:32] * w_m1b[31:0] +
                    w_m1a[31:0] * w_m1b[63:32])} << 32);
        end
        if (i_cmd.mul2) begin
            r_p2 <= w_m2a[31:0] * w_m2b[31:0] +
                    ({{32{1'b0}}, (w_m2a[63:32] * w_m2b[31:0] +
                    w_m2a[31:0] * w_m2b[63:32])} << 32);
            r_p3 <= r_p1;
        end
        if (i_cmd.comb) begin
            case (r_op)
                OP_ADD: begin r_n <= r_p3 + r_p2; r_d <= r_p1; end
                OP_SUB: begin r_n <= r_p3 - r_p2; r_d <= r_p1; end
                OP_MUL, OP_DIV: begin r_n <= r_p1; r_d <= r_p2; end
                OP_NEG: begin r_n <= RES_W'(0) - r_an; r_d <= r_ad; end
                default: begin r_n <= r_an; r_d <= r_ad; end
            endcase
        end
        if (i_cmd.sign && r_d[RES_W-1]) begin
            r_n <= RES_W'(0) - r_n;
            r_d <= RES_W'(0) - r_d;
        end
        if (i_cmd.gcd_init) begin
            r_x <= w_mag_n;
            r_y <= r_d;
        end
        if (i_cmd.gcd_step) begin
            r_x <= r_y;
            r_y <= w_rem;
        end
        if (i_cmd.store_qn) begin
            r_qn <= r_n[RES_W-1] ? (RES_W'(0) - w_quot) : w_quot;
        end
        if (i_cmd.store_qd) begin
            r_d <= w_quot;
        end
        if (i_cmd.fin) begin
            r_n <= r_qn;
        end
    end

    // r_g tracks the last nonzero remainder chain value
    always_ff @(posedge i_clk) begin
        if (i_cmd.gcd_step) begin
            r_g <= r_y;
        end
    end

    assign o_sts.is_neg_op   = (r_op == OP_NEG);
    assign o_sts.need_reduce = !r_d[RES_W-1] && (r_d > RES_W'(1)) && (r_n != '0);
    assign o_sts.y_zero      = (r_y == '0);
    assign o_sts.div_done    = w_div_done;
    assign o_res_num         = r_n;
    assign o_res_den         = r_d;
endmodule
`default_nettype wire

// ----- rtl/core/rau_ctrl.sv -----
// rau_ctrl: sequencing state machine for the rational arithmetic unit
// depends on rau_pkg
`default_nettype none
module rau_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_fire,
    input  wire logic          i_out_fire,
    input  wire rau_pkg::t_sts i_sts,
    output rau_pkg::t_cmd      o_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid
);
    import rau_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (i_in_fire) begin n_state = ST_MUL1; end
            ST_MUL1:     n_state = ST_MUL2;
            ST_MUL2:     n_state = ST_COMB;
            ST_COMB:     n_state = i_sts.is_neg_op ? ST_OUT : ST_SIGN;
            ST_SIGN:     n_state = ST_GCD_INIT;
            ST_GCD_INIT: n_state = i_sts.need_reduce ? ST_GCD_DIV : ST_OUT;
            ST_GCD_DIV:  n_state = i_sts.y_zero ? ST_QN : ST_GCD_STEP;
            ST_GCD_STEP: if (i_sts.div_done) begin n_state = ST_GCD_DIV; end
            ST_QN:       if (i_sts.div_done) begin n_state = ST_QD; end
            ST_QD:       if (i_sts.div_done) begin n_state = ST_FIN; end
            ST_FIN:      n_state = ST_OUT;
            ST_OUT:      if (i_out_fire) begin n_state = ST_IDLE; end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = (r_state == ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
        case (r_state)
            ST_IDLE:     o_cmd.load = i_in_fire;
            ST_MUL1:     o_cmd.mul1 = 1'b1;
            ST_MUL2:     o_cmd.mul2 = 1'b1;
            ST_COMB:     o_cmd.comb = 1'b1;
            ST_SIGN:     o_cmd.sign = 1'b1;
            ST_GCD_INIT: o_cmd.gcd_init = 1'b1;
            ST_GCD_DIV: begin
                if (!i_sts.y_zero) begin
                    o_cmd.div_start = 1'b1;
                end else begin
                    o_cmd.div_start  = 1'b1;
                    o_cmd.div_sel_qn = 1'b1;
                end
            end
            ST_GCD_STEP: o_cmd.gcd_step = i_sts.div_done;
            ST_QN: begin
                o_cmd.store_qn = i_sts.div_done;
                if (i_sts.div_done) begin
                    o_cmd.div_start  = 1'b1;
                    o_cmd.div_sel_qd = 1'b1;
                end
            end
            ST_QD: o_cmd.store_qd = i_sts.div_done;
            ST_FIN: o_cmd.fin = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/rational_arith_unit_core.sv -----
// rational_arith_unit_core: top level of the rational arithmetic unit
// depends on rau_pkg, rau_ctrl, rau_dp, rau_div
//
// usage:
//   s_axis carries one request: operation in tuser, fractions a and b in tdata.
//   m_axis returns one result: numerator and denominator, normalized except
//   for negate, at 64 bits in tdata plus a zero-denominator flag in tuser.
//   one request is in flight at a time; s_axis_tready is high only idle.
//   after the accepting edge the controller steps MUL1, MUL2 and COMB; negate
//   then goes to OUT, other results pass SIGN and GCD_INIT, unreduced ones go
//   to OUT, and the rest run one euclid step per division on the bit-serial
//   64-bit divider shared by the gcd and the two final divisions.
//   a new request is taken the cycle after the result is accepted.
//   the result is held on m_axis until m_axis_tready takes it; a stalled
//   receiver keeps the unit from taking the next request.
//   synchronous reset returns the controller to idle with nothing pending.
//
`default_nettype none
module rational_arith_unit_core #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
    input  wire logic [127:0] s_axis_tdata,
    // operation[2:0]
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // res_num[63:0], res_den[127:64]
    output logic [127:0]      m_axis_tdata,
    // zero_den[0]
    output logic              m_axis_tuser
);
    import rau_pkg::*;

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [RES_W-1:0] w_num, w_den;
    logic             w_in_fire, w_out_fire;

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_fire = m_axis_tvalid && m_axis_tready;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (w_in_fire),
        .i_out_fire  (w_out_fire),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    rau_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_op      (s_axis_tuser),
        .i_a_num   (s_axis_tdata[31:0]),
        .i_a_den   (s_axis_tdata[63:32]),
        .i_b_num   (s_axis_tdata[95:64]),
        .i_b_den   (s_axis_tdata[127:96]),
        .o_sts     (w_sts),
        .o_res_num (w_num),
        .o_res_den (w_den)
    );

    assign m_axis_tdata = {w_den, w_num};
    assign m_axis_tuser = (w_den == '0);

    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("ready and result valid together");
    a_out_after_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire |=> s_axis_tready)
        else $error("not idle after result taken");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");
endmodule
`default_nettype wire
